### design/heq_pkg.sv
package heq_pkg;

  localparam int NUM_BINS   = 256;
  localparam int PIX_W      = 8;
  localparam int BIN_IDX_W  = $clog2(NUM_BINS);
  localparam int MAX_PIXELS = 1048576;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int SPAN_W     = PIX_W;
  localparam int PROD_W     = SPAN_W + CNT_W;
  localparam int Q_W        = PIX_W;
  localparam int STEP_W     = $clog2(Q_W);

  // func codes carried on tuser
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ACCUM = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_WR,
    ST_BLD,
    ST_MAP_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

### design/heq_ram.sv
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/histogram_equalizer_top.sv
// two-pass histogram equalizer for 8-bit gray pixels. tuser selects the
// function: clear empties the histogram and frame statistics; accumulate
// counts the pixel into its bin and tracks count, min and max (one
// read-modify-write of the bin memory); an accumulate transfer with tlast
// set then rewrites the 256 bins as exclusive cumulative counts, one bin per
// cycle through the single memory port pair; a map transfer returns
// floor((max-min)*cum(p)/count): bin read, one multiply, then 8 restoring
// divide steps on one compare/subtract unit. map gives 0 before the table is
// built or for an empty frame. accumulate transfers after the build are
// ignored until clear, and pixels past the capacity limit are not counted.
// the input is not ready while an item is in work; a finished result sits
// in the output register, so the next transfer can be taken while it waits.
// bins are cleared by per-entry valid bits, so there is no clearing pass
// after reset.
module histogram_equalizer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] pixel_value
  input  logic       s_axis_tlast,   // last_pixel
  input  logic [1:0] s_axis_tuser,   // [1:0] func
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] equalized_value
);

  heq_pkg::state_t state, state_next;

  // frame statistics
  logic [heq_pkg::CNT_W-1:0] pixel_count;
  logic [heq_pkg::PIX_W-1:0] frame_min, frame_max;
  logic                      table_ready;

  // per-bin valid bits, an invalid bin reads as zero
  logic [heq_pkg::NUM_BINS-1:0] bin_valid;
  logic                         rd_valid;

  // latched item
  logic [heq_pkg::PIX_W-1:0] pix;
  logic                      last_r;

  // table build sweep
  logic [heq_pkg::BIN_IDX_W:0]   bidx;
  logic [heq_pkg::CNT_W-1:0]     running;

  // divider
  logic [heq_pkg::PROD_W-1:0] rem, dsh, rem_sub;
  logic                       ge;
  logic [heq_pkg::STEP_W-1:0] step;
  logic [heq_pkg::Q_W-1:0]    quot;
  logic [heq_pkg::SPAN_W-1:0] span;

  // bin memory port
  logic                          ram_we, ram_re;
  logic [heq_pkg::BIN_IDX_W-1:0] ram_waddr, ram_raddr;
  logic [heq_pkg::CNT_W-1:0]     ram_wdata, rd_data, eff_rd;

  logic in_xfer, out_free, count_full, map_zero;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign count_full = pixel_count >= heq_pkg::CNT_W'(heq_pkg::MAX_PIXELS);
  assign map_zero   = !table_ready || (pixel_count == '0);
  assign eff_rd     = rd_valid ? rd_data : '0;
  assign span       = frame_max - frame_min;

  // compare/subtract unit, reused by every divide step
  assign ge      = rem >= dsh;
  assign rem_sub = rem - dsh;

  heq_ram #(
    .WIDTH(heq_pkg::CNT_W),
    .DEPTH(heq_pkg::NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      heq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser)
            heq_pkg::FUNC_ACCUM: begin
              if (!table_ready) begin
                if (!count_full) begin
                  state_next = heq_pkg::ST_ACC_WR;
                end else if (s_axis_tlast) begin
                  state_next = heq_pkg::ST_BLD;
                end
              end
            end
            heq_pkg::FUNC_MAP: begin
              state_next = map_zero ? heq_pkg::ST_OUT : heq_pkg::ST_MAP_MUL;
            end
            default: state_next = heq_pkg::ST_IDLE;
          endcase
        end
      end
      heq_pkg::ST_ACC_WR: begin
        state_next = last_r ? heq_pkg::ST_BLD : heq_pkg::ST_IDLE;
      end
      heq_pkg::ST_BLD: begin
        if (bidx == (heq_pkg::BIN_IDX_W + 1)'(heq_pkg::NUM_BINS)) begin
          state_next = heq_pkg::ST_IDLE;
        end
      end
      heq_pkg::ST_MAP_MUL: state_next = heq_pkg::ST_DIV;
      heq_pkg::ST_DIV: begin
        if (step == '0) begin
          state_next = heq_pkg::ST_OUT;
        end
      end
      heq_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = heq_pkg::ST_IDLE;
        end
      end
      default: state_next = heq_pkg::ST_IDLE;
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = s_axis_tdata;
    ram_we        = 1'b0;
    ram_waddr     = pix;
    ram_wdata     = eff_rd + heq_pkg::CNT_W'(1);
    case (state)
      heq_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        // speculative bin read, harmless for other functions
        ram_re        = s_axis_tvalid;
      end
      heq_pkg::ST_ACC_WR: begin
        ram_we = 1'b1;
      end
      heq_pkg::ST_BLD: begin
        // read bin bidx while writing the prefix of bin bidx-1
        ram_re    = !bidx[heq_pkg::BIN_IDX_W];
        ram_raddr = bidx[heq_pkg::BIN_IDX_W-1:0];
        ram_we    = bidx != '0;
        ram_waddr = bidx[heq_pkg::BIN_IDX_W-1:0] - heq_pkg::BIN_IDX_W'(1);
        ram_wdata = running;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= heq_pkg::ST_IDLE;
      pixel_count   <= '0;
      frame_min     <= '1;
      frame_max     <= '0;
      table_ready   <= 1'b0;
      bin_valid     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        bin_valid[ram_waddr] <= 1'b1;
      end
      case (state)
        heq_pkg::ST_IDLE: begin
          if (in_xfer && s_axis_tuser == heq_pkg::FUNC_CLEAR) begin
            pixel_count <= '0;
            frame_min   <= '1;
            frame_max   <= '0;
            table_ready <= 1'b0;
            bin_valid   <= '0;
          end
        end
        heq_pkg::ST_ACC_WR: begin
          pixel_count <= pixel_count + heq_pkg::CNT_W'(1);
          if (pix < frame_min) begin
            frame_min <= pix;
          end
          if (pix > frame_max) begin
            frame_max <= pix;
          end
        end
        heq_pkg::ST_BLD: begin
          if (bidx == (heq_pkg::BIN_IDX_W + 1)'(heq_pkg::NUM_BINS)) begin
            table_ready <= 1'b1;
          end
        end
        default: begin
        end
      endcase
      // output register, loads only when empty or being drained
      if (state == heq_pkg::ST_OUT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid <= bin_valid[ram_raddr];
    end
    case (state)
      heq_pkg::ST_IDLE: begin
        pix     <= s_axis_tdata;
        last_r  <= s_axis_tlast;
        bidx    <= '0;
        running <= '0;
        quot    <= '0;
      end
      heq_pkg::ST_BLD: begin
        bidx <= bidx + (heq_pkg::BIN_IDX_W + 1)'(1);
        if (bidx != '0) begin
          running <= running + eff_rd;
        end
      end
      heq_pkg::ST_MAP_MUL: begin
        // 8 x 21 product, quotient is known to fit in 8 bits
        rem  <= heq_pkg::PROD_W'(span) * heq_pkg::PROD_W'(eff_rd);
        dsh  <= heq_pkg::PROD_W'(pixel_count) << (heq_pkg::Q_W - 1);
        step <= heq_pkg::STEP_W'(heq_pkg::Q_W - 1);
      end
      heq_pkg::ST_DIV: begin
        if (ge) begin
          rem <= rem_sub;
        end
        quot <= {quot[heq_pkg::Q_W-2:0], ge};
        dsh  <= dsh >> 1;
        step <= step - heq_pkg::STEP_W'(1);
      end
      heq_pkg::ST_OUT: begin
        if (out_free) begin
          m_axis_tdata <= quot;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // table becomes ready only after every bin has been rewritten
  a_build_covers_all: assert property (@(posedge clk) disable iff (rst)
    $rose(table_ready) |-> (&bin_valid))
    else $error("table ready with unwritten bins");

  // equalized value never exceeds the frame span
  a_quot_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == heq_pkg::ST_OUT) && !map_zero |-> (quot <= span))
    else $error("mapped value beyond frame span");

  // pixel count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    pixel_count <= heq_pkg::CNT_W'(heq_pkg::MAX_PIXELS))
    else $error("pixel count beyond capacity");
`endif

endmodule
